>>> hw/rtl/domain_transform_row_box_filter_defines.svh
// Assertion macros used by the checker file.
`ifndef DOMAIN_TRANSFORM_ROW_BOX_FILTER_DEFINES_SVH
`define DOMAIN_TRANSFORM_ROW_BOX_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DTRBF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtrbf assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DTRBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtrbf assertion failed");

`endif

>>> hw/rtl/dtrbf_pkg.sv
package dtrbf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PTR_W     = $clog2(MAX_WIDTH + 1);
    localparam int CHAN_W    = 16;
    localparam int SUM_W     = CHAN_W + ADDR_W;
    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd1;

    typedef struct packed {
        logic              operation;
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_c;
        logic [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [CHAN_W-1:0] out_a;
        logic [CHAN_W-1:0] out_b;
        logic [CHAN_W-1:0] out_c;
        logic              row_done;
    } t_res;

endpackage

>>> hw/rtl/domain_transform_row_box_filter.sv
// Channel     | Direction | Handshake
// command     | in        | start, busy (taken when start & !busy)
// result      | out       | o_strobe, one cycle, no backpressure
// config      | in        | i_cfg_valid, o_cfg_ready (always ready)
//
// A load is written in the cycle it is taken and leaves the block ready. A read
// holds busy through the window search (lower, then upper pointer steps), the
// fetch and subtraction of prefix sums, the shared restoring divider for all
// three channels (skipped on an empty window) and the result state.
// Reset is synchronous, active low; memories are not cleared: prefix entry
// zero is supplied as a constant. The receiver cannot stall results.
module domain_transform_row_box_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dtrbf_pkg::t_cmd                     i_cmd,
    output logic                                o_strobe,
    output dtrbf_pkg::t_res                     o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dtrbf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtrbf_pkg::POS_W-1:0]         i_cfg_data
);
    import dtrbf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HERE, S_HWAIT, S_LO, S_LOC, S_HI, S_HIC,
        S_SHI, S_SLO, S_SDIFF, S_DIV, S_OUT
    } t_state;

    typedef logic [3*SUM_W-1:0] t_sums;

    t_state               r_state;
    logic [POS_W-1:0]     r_radius;
    logic [PTR_W-1:0]     r_row_width;
    logic [PTR_W-1:0]     r_load_count, r_col, r_lo, r_hi;
    logic [SUM_W-1:0]     r_run [3];
    logic [POS_W-1:0]     r_here, r_pos_q;
    t_sums                r_sum_q, r_shi;
    logic [SUM_W-1:0]     r_diff [3];
    logic [1:0]           r_ch;
    logic [$clog2(SUM_W)-1:0] r_step;
    logic [ADDR_W:0]      r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [CHAN_W-1:0]    r_res [3];

    logic [POS_W-1:0]     pos_mem [MAX_WIDTH];
    t_sums                sum_mem [MAX_WIDTH];

    logic [PTR_W-1:0]     w;
    logic [ADDR_W-1:0]    pos_addr, sum_addr;
    logic [PTR_W-1:0]     hi_m1, lo_m1;
    logic [PTR_W-1:0]     cnt;
    logic [POS_W:0]       lo_lhs, hi_rhs;
    logic [SUM_W-1:0]     base [3];
    logic [SUM_W-1:0]     load_val [3];
    logic [ADDR_W+1:0]    trial;
    logic                 do_load;
    t_sums                slo;

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_result    = '{out_a: r_res[0], out_b: r_res[1], out_c: r_res[2],
                           row_done: (r_col + 1'b1 >= w)};

    // clamp width to 1..MAX_WIDTH
    always_comb begin
        if (r_row_width == '0) begin
            w = PTR_W'(1);
        end else if (r_row_width > PTR_W'(MAX_WIDTH)) begin
            w = PTR_W'(MAX_WIDTH);
        end else begin
            w = r_row_width;
        end
    end

    // window edge compares and divider step
    assign lo_lhs = {1'b0, r_pos_q} + {1'b0, r_radius};
    assign hi_rhs = {1'b0, r_here} + {1'b0, r_radius};
    assign hi_m1  = r_hi - 1'b1;
    assign lo_m1  = r_lo - 1'b1;
    assign cnt    = (r_hi > r_lo) ? (r_hi - r_lo) : '0;
    assign trial  = {r_rem, r_quo[SUM_W-1]} - {1'b0, cnt};
    assign slo    = (r_lo == '0) ? '0 : r_sum_q;

    // load path: running sums restart on the first pixel of a row
    assign do_load = start && !busy && (i_cmd.operation == OP_LOAD) && (r_load_count < w);
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            base[c] = (r_load_count == '0) ? '0 : r_run[c];
        end
        load_val[0] = base[0] + SUM_W'(i_cmd.chan_a);
        load_val[1] = base[1] + SUM_W'(i_cmd.chan_b);
        load_val[2] = base[2] + SUM_W'(i_cmd.chan_c);
    end

    // read addresses per state
    always_comb begin
        unique case (r_state)
            S_LO:    pos_addr = r_lo[ADDR_W-1:0];
            S_HI:    pos_addr = r_hi[ADDR_W-1:0];
            default: pos_addr = r_col[ADDR_W-1:0];
        endcase
        sum_addr = (r_state == S_SHI) ? hi_m1[ADDR_W-1:0] : lo_m1[ADDR_W-1:0];
    end

    // memories: write on load, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            pos_mem[r_load_count[ADDR_W-1:0]] <= i_cmd.position;
            sum_mem[r_load_count[ADDR_W-1:0]] <= {load_val[0], load_val[1], load_val[2]};
        end
        r_pos_q <= pos_mem[pos_addr];
        r_sum_q <= sum_mem[sum_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_radius     <= POS_W'(65536);
            r_row_width  <= PTR_W'(1024);
            r_load_count <= '0;
            r_col        <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_BOX_RADIUS) begin
                    r_radius <= i_cfg_data;
                end else if (i_cfg_index == REG_ROW_WIDTH) begin
                    r_row_width <= i_cfg_data[PTR_W-1:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (do_load) begin
                        r_load_count <= r_load_count + 1'b1;
                        for (int c = 0; c < 3; c++) r_run[c] <= load_val[c];
                    end else if (start && i_cmd.operation == OP_READ
                                 && r_load_count >= w) begin
                        if (r_col >= w) begin
                            r_load_count <= '0;
                            r_col        <= '0;
                            r_lo         <= '0;
                            r_hi         <= '0;
                        end else begin
                            if (r_lo > w) r_lo <= w;
                            if (r_hi > w) r_hi <= w;
                            r_state <= S_HERE;
                        end
                    end
                end
                S_HERE:  r_state <= S_HWAIT;
                S_HWAIT: begin
                    r_here  <= r_pos_q;
                    r_state <= S_LO;
                end
                // advance lower edge past positions at or below here - radius
                S_LO:  r_state <= (r_lo < w) ? S_LOC : S_HI;
                S_LOC: begin
                    if (lo_lhs <= {1'b0, r_here}) begin
                        r_lo    <= r_lo + 1'b1;
                        r_state <= S_LO;
                    end else begin
                        r_state <= S_HI;
                    end
                end
                // advance upper edge past positions at or below here + radius
                S_HI:  r_state <= (r_hi < w) ? S_HIC : S_SHI;
                S_HIC: begin
                    if ({1'b0, r_pos_q} <= hi_rhs) begin
                        r_hi    <= r_hi + 1'b1;
                        r_state <= S_HI;
                    end else begin
                        r_state <= S_SHI;
                    end
                end
                S_SHI: r_state <= S_SLO;
                S_SLO: begin
                    r_shi   <= (r_hi == '0) ? '0 : r_sum_q;
                    r_state <= S_SDIFF;
                end
                S_SDIFF: begin
                    r_diff[0] <= r_shi[3*SUM_W-1:2*SUM_W] - slo[3*SUM_W-1:2*SUM_W];
                    r_diff[1] <= r_shi[2*SUM_W-1:SUM_W]   - slo[2*SUM_W-1:SUM_W];
                    r_diff[2] <= r_shi[SUM_W-1:0]         - slo[SUM_W-1:0];
                    r_quo     <= r_shi[3*SUM_W-1:2*SUM_W] - slo[3*SUM_W-1:2*SUM_W];
                    r_rem     <= '0;
                    r_step    <= '0;
                    r_ch      <= '0;
                    if (cnt == '0) begin
                        for (int c = 0; c < 3; c++) r_res[c] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                // one quotient bit per cycle, channels in turn
                S_DIV: begin
                    if (r_step == $bits(r_step)'(SUM_W - 1)) begin
                        r_res[r_ch] <= {r_quo[CHAN_W-2:0], ~trial[ADDR_W+1]};
                        r_step      <= '0;
                        r_rem       <= '0;
                        if (r_ch == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch  <= r_ch + 1'b1;
                            r_quo <= r_diff[r_ch + 1'b1];
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                        if (!trial[ADDR_W+1]) begin
                            r_rem <= trial[ADDR_W:0];
                            r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[ADDR_W-1:0], r_quo[SUM_W-1]};
                            r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                        end
                    end
                end
                S_OUT: begin
                    if (r_col + 1'b1 >= w) begin
                        r_load_count <= '0;
                        r_col        <= '0;
                        r_lo         <= '0;
                        r_hi         <= '0;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/dtrbf_checker.sv
`include "domain_transform_row_box_filter_defines.svh"

module dtrbf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dtrbf_pkg::t_cmd  i_cmd,
    input logic             o_strobe
);
    import dtrbf_pkg::*;

    // a result ends the transaction and frees the block
    `DTRBF_ASSERT_NEXT(a_strobe_frees, o_strobe, !busy)
    // a result only comes out of a running read
    `DTRBF_ASSERT_SAME(a_strobe_busy, o_strobe, busy && $past(busy))
    // loads finish in the cycle they are taken
    `DTRBF_ASSERT_NEXT(a_load_one_cycle, start && !busy && i_cmd.operation == OP_LOAD, !busy)

endmodule

bind domain_transform_row_box_filter dtrbf_checker u_dtrbf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe)
);
